[design/rpc_pkg.sv]
// rpc_pkg: shared types and constants of the region profile collator.
// Holds the transaction structs, opcode and result codes, FSM state type
// and the controller/datapath command and status bundles. No dependencies.
`default_nettype none

package rpc_pkg;

	localparam int ID_W = 32;
	localparam int TS_W = 64;

	// event opcodes
	localparam logic [1:0] EK_FRAME = 2'd0;
	localparam logic [1:0] EK_BEGIN = 2'd1;
	localparam logic [1:0] EK_END   = 2'd2;

	// result codes
	localparam logic [2:0] RK_SUMMARY   = 3'd0;
	localparam logic [2:0] RK_RECORD    = 3'd1;
	localparam logic [2:0] RK_OVERFLOW  = 3'd2;
	localparam logic [2:0] RK_UNDERFLOW = 3'd3;
	localparam logic [2:0] RK_FULL      = 3'd4;
	localparam logic [2:0] RK_ZERO_ID   = 3'd5;

	typedef struct packed {
		logic [1:0]      event_kind;
		logic [TS_W-1:0] timestamp;
		logic [ID_W-1:0] region_id;
	} evt_t;

	typedef struct packed {
		logic [2:0]      result_kind;
		logic [ID_W-1:0] out_region;
		logic [31:0]     call_count;
		logic [TS_W-1:0] clock_total;
		logic [TS_W-1:0] frame_begin;
		logic [TS_W-1:0] frame_end;
		logic            last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP,
		ST_MOD,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_UPD_WR,
		ST_ERR,
		ST_SUM,
		ST_REC_RD,
		ST_REC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load_item;
		logic       push;
		logic       pop_rd;
		logic       pop_cap;
		logic       mod_step;
		logic       probe_rd;
		logic       probe_next;
		logic       create;
		logic       upd_rd;
		logic       upd_wr;
		logic       err_set;
		logic [2:0] err_kind;
		logic       err_emit;
		logic       sum_emit;
		logic       rec_rd;
		logic       rec_emit;
		logic       rec_next;
		logic       tbl_clear;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] kind;
		logic       enable;
		logic       id_zero;
		logic       stack_full;
		logic       stack_empty;
		logic       mod_last;
		logic       slot_vld;
		logic       key_match;
		logic       table_full;
		logic       probe_last;
		logic       rec_last;
		logic       used_zero;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

[design/rpc_ctrl.sv]
// rpc_ctrl: sequencing state machine of the region profile collator.
// Uses rpc_pkg; drives the datapath only through cmd_t, reads sts_t.
`default_nettype none

module rpc_ctrl
	import rpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic evt_valid,
	output logic      evt_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		evt_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				evt_stall = 1'b0;
				if (evt_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (sts.enable) begin
					case (sts.kind)
						EK_FRAME: state_d = ST_SUM;
						EK_BEGIN: begin
							if (sts.id_zero) begin
								cmd.err_set  = 1'b1;
								cmd.err_kind = RK_ZERO_ID;
								state_d      = ST_ERR;
							end else if (sts.stack_full) begin
								cmd.err_set  = 1'b1;
								cmd.err_kind = RK_OVERFLOW;
								state_d      = ST_ERR;
							end else begin
								cmd.push = 1'b1;
							end
						end
						EK_END: begin
							if (sts.stack_empty) begin
								cmd.err_set  = 1'b1;
								cmd.err_kind = RK_UNDERFLOW;
								state_d      = ST_ERR;
							end else begin
								cmd.pop_rd = 1'b1;
								state_d    = ST_POP;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_POP: begin
				cmd.pop_cap = 1'b1;
				state_d     = ST_MOD;
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_d = ST_PROBE_RD;
			end
			ST_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_d      = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				if (!sts.slot_vld) begin
					if (sts.table_full) begin
						cmd.err_set  = 1'b1;
						cmd.err_kind = RK_FULL;
						state_d      = ST_ERR;
					end else begin
						cmd.create = 1'b1;
						state_d    = ST_IDLE;
					end
				end else if (sts.key_match) begin
					cmd.upd_rd = 1'b1;
					state_d    = ST_UPD_WR;
				end else if (sts.probe_last) begin
					cmd.err_set  = 1'b1;
					cmd.err_kind = RK_FULL;
					state_d      = ST_ERR;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = ST_PROBE_RD;
				end
			end
			ST_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.err_emit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SUM: begin
				if (sts.out_free) begin
					cmd.sum_emit = 1'b1;
					if (sts.used_zero) begin
						cmd.tbl_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_REC_RD;
					end
				end
			end
			ST_REC_RD: begin
				cmd.rec_rd = 1'b1;
				state_d    = ST_REC;
			end
			ST_REC: begin
				if (sts.out_free) begin
					cmd.rec_emit = 1'b1;
					if (sts.rec_last) begin
						cmd.tbl_clear = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.rec_next = 1'b1;
						state_d      = ST_REC_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[design/rpc_dpath.sv]
// rpc_dpath: datapath of the region profile collator: open-region stack,
// hash slot table, record store, modulo unit and the result register.
// Uses rpc_pkg; commanded by rpc_ctrl.
`default_nettype none

module rpc_dpath
	import rpc_pkg::*;
#(
	parameter int TABLE_SLOTS = 32,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire evt_t evt,
	input  wire logic cfg_valid,
	input  wire logic cfg_data,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int RW = $clog2(TABLE_SLOTS + 1);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [SW:0] NMOD = (SW+1)'(TABLE_SLOTS);

	evt_t            item_q;
	logic            enable_q;
	logic [TS_W-1:0] frame_start_q;

	// open-region stack
	logic [ID_W-1:0] stk_ids   [STACK_DEPTH];
	logic [TS_W-1:0] stk_times [STACK_DEPTH];
	logic [DW-1:0]   depth_q;
	logic [DW-1:0]   depth_m1;
	logic [ID_W-1:0] stk_id_rd_q;
	logic [TS_W-1:0] stk_time_rd_q;

	logic [ID_W-1:0] key_q;
	logic [TS_W-1:0] elapsed_q;
	logic [ID_W-1:0] key_sh_q;
	logic [SW-1:0]   slot_q;
	logic [SW-1:0]   mod_next;
	logic [1:0]      mod_cnt_q;
	logic [SW-1:0]   off_q;

	// slot table
	logic [TABLE_SLOTS-1:0] slot_vld_q;
	logic [ID_W-1:0]        slot_keys [TABLE_SLOTS];
	logic [SW-1:0]          slot_recs [TABLE_SLOTS];
	logic [ID_W-1:0]        slot_key_rd_q;
	logic [SW-1:0]          slot_rec_rd_q;
	logic                   slot_vld_rd_q;

	// record store
	logic [ID_W-1:0] rec_ids    [TABLE_SLOTS];
	logic [31:0]     rec_calls  [TABLE_SLOTS];
	logic [TS_W-1:0] rec_clocks [TABLE_SLOTS];
	logic [ID_W-1:0] rec_id_rd_q;
	logic [31:0]     rec_calls_rd_q;
	logic [TS_W-1:0] rec_clocks_rd_q;
	logic [SW-1:0]   rec_rd_addr;
	logic [SW-1:0]   rec_sel_q;
	logic [RW-1:0]   rec_used_q;
	logic [SW-1:0]   idx_q;
	logic [SW-1:0]   rec_wr_addr;
	logic [31:0]     calls_wr;
	logic [TS_W-1:0] clocks_wr;

	logic [2:0]      err_kind_q;
	logic [ID_W-1:0] err_region_q;
	res_t            res_q;
	res_t            res_d;
	logic            res_valid_q;
	logic            out_free;

	assign depth_m1 = depth_q - 1'b1;
	assign out_free = !res_valid_q || !res_stall;

	// item capture and configuration
	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			frame_start_q <= '0;
		end else begin
			if (cfg_valid) enable_q <= cfg_data;
			if (cmd.sum_emit) frame_start_q <= item_q.timestamp;
		end
	end

	// stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.push) begin
			depth_q <= depth_q + 1'b1;
		end else if (cmd.pop_rd) begin
			depth_q <= depth_m1;
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_ids[depth_q[AW-1:0]]   <= item_q.region_id;
			stk_times[depth_q[AW-1:0]] <= item_q.timestamp;
		end
		stk_id_rd_q   <= stk_ids[depth_m1[AW-1:0]];
		stk_time_rd_q <= stk_times[depth_m1[AW-1:0]];
	end

	// key % TABLE_SLOTS, eight key bits per cycle
	always_comb begin
		logic [SW:0] t;
		logic [SW-1:0] r;
		r = slot_q;
		for (int i = 0; i < 8; i++) begin
			t = {r, key_sh_q[ID_W-1-i]};
			if (t >= NMOD) t = t - NMOD;
			r = t[SW-1:0];
		end
		mod_next = r;
	end

	// popped region, hash walk and probe position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q <= '0;
		end else if (cmd.pop_cap) begin
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_cap) begin
			key_q     <= stk_id_rd_q;
			elapsed_q <= item_q.timestamp - stk_time_rd_q;
			key_sh_q  <= stk_id_rd_q;
			slot_q    <= '0;
			off_q     <= '0;
		end else if (cmd.mod_step) begin
			key_sh_q <= key_sh_q << 8;
			slot_q   <= mod_next;
		end else if (cmd.probe_next) begin
			off_q  <= off_q + 1'b1;
			slot_q <= (slot_q == SW'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (cmd.tbl_clear) begin
			slot_vld_q <= '0;
		end else if (cmd.create) begin
			slot_vld_q[slot_q] <= 1'b1;
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (cmd.create) begin
			slot_keys[slot_q] <= key_q;
			slot_recs[slot_q] <= rec_used_q[SW-1:0];
		end
		if (cmd.probe_rd) begin
			slot_key_rd_q <= slot_keys[slot_q];
			slot_rec_rd_q <= slot_recs[slot_q];
			slot_vld_rd_q <= slot_vld_q[slot_q];
		end
	end

	// record count, update target, dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_used_q <= '0;
		end else if (cmd.tbl_clear) begin
			rec_used_q <= '0;
		end else if (cmd.create) begin
			rec_used_q <= rec_used_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_rd) rec_sel_q <= slot_rec_rd_q;
		if (cmd.sum_emit) begin
			idx_q <= '0;
		end else if (cmd.rec_next) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// record write data: new record or saturating/wrapping update
	always_comb begin
		if (cmd.create) begin
			rec_wr_addr = rec_used_q[SW-1:0];
			calls_wr    = 32'd1;
			clocks_wr   = elapsed_q;
		end else begin
			rec_wr_addr = rec_sel_q;
			calls_wr    = (rec_calls_rd_q == '1) ? rec_calls_rd_q : rec_calls_rd_q + 1'b1;
			clocks_wr   = rec_clocks_rd_q + elapsed_q;
		end
	end

	assign rec_rd_addr = cmd.rec_rd ? idx_q : slot_rec_rd_q;

	// record memory
	always_ff @(posedge clk) begin
		if (cmd.create) rec_ids[rec_wr_addr] <= key_q;
		if (cmd.create || cmd.upd_wr) begin
			rec_calls[rec_wr_addr]  <= calls_wr;
			rec_clocks[rec_wr_addr] <= clocks_wr;
		end
		if (cmd.rec_rd || cmd.upd_rd) begin
			rec_id_rd_q     <= rec_ids[rec_rd_addr];
			rec_calls_rd_q  <= rec_calls[rec_rd_addr];
			rec_clocks_rd_q <= rec_clocks[rec_rd_addr];
		end
	end

	// fault capture
	always_ff @(posedge clk) begin
		if (cmd.err_set) begin
			err_kind_q <= cmd.err_kind;
			case (cmd.err_kind)
				RK_OVERFLOW: err_region_q <= item_q.region_id;
				RK_FULL:     err_region_q <= key_q;
				default:     err_region_q <= '0;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.err_emit || cmd.sum_emit || cmd.rec_emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// next result payload
	always_comb begin
		res_d = res_q;
		if (cmd.err_emit) begin
			res_d             = '0;
			res_d.result_kind = err_kind_q;
			res_d.out_region  = err_region_q;
			res_d.last        = 1'b1;
		end else if (cmd.sum_emit) begin
			res_d             = '0;
			res_d.result_kind = RK_SUMMARY;
			res_d.frame_begin = frame_start_q;
			res_d.frame_end   = item_q.timestamp;
			res_d.last        = (rec_used_q == '0);
		end else if (cmd.rec_emit) begin
			res_d             = '0;
			res_d.result_kind = RK_RECORD;
			res_d.out_region  = rec_id_rd_q;
			res_d.call_count  = rec_calls_rd_q;
			res_d.clock_total = rec_clocks_rd_q;
			res_d.last        = ((RW'(idx_q) + 1'b1) == rec_used_q);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// status to controller
	always_comb begin
		sts             = '0;
		sts.kind        = item_q.event_kind;
		sts.enable      = enable_q;
		sts.id_zero     = (item_q.region_id == '0);
		sts.stack_full  = (depth_q == DW'(STACK_DEPTH));
		sts.stack_empty = (depth_q == '0);
		sts.mod_last    = (mod_cnt_q == 2'd3);
		sts.slot_vld    = slot_vld_rd_q;
		sts.key_match   = (slot_key_rd_q == key_q);
		sts.table_full  = (rec_used_q == RW'(TABLE_SLOTS));
		sts.probe_last  = (off_q == SW'(TABLE_SLOTS - 1));
		sts.rec_last    = ((RW'(idx_q) + 1'b1) == rec_used_q);
		sts.used_zero   = (rec_used_q == '0);
		sts.out_free    = out_free;
	end

endmodule

`default_nettype wire

[design/region_profile_collator.sv]
// Region profile collator top level. One event in flight; the input stalls until it is
// finished. A begin pushes or errors (zero id, overflow); an end errors on underflow,
// else pops, takes key % TABLE_SLOTS eight bits at a time, reads and compares slots,
// then creates or updates a record or reports a full table. A frame marker emits a
// summary, one result per record, clears the table. Reset (arst_n, async): stack and
// table empty, collect_enable 1, frame start 0. Uses rpc_pkg, rpc_ctrl, rpc_dpath.
`default_nettype none

module region_profile_collator
	import rpc_pkg::*;
#(
	parameter int TABLE_SLOTS = 32,
	parameter int STACK_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic evt_valid,
	output logic      evt_stall,
	input  wire evt_t evt,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	rpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rpc_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire
